/* src/stx_ack_etx_response_deframer_assert.svh */
// Assertion macros shared by the response deframer modules.
`ifndef STX_ACK_ETX_RESPONSE_DEFRAMER_ASSERT_SVH
`define STX_ACK_ETX_RESPONSE_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define STXD_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define STXD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* src/stxd_pkg.sv */
// Types, byte codes and status codes of the STX/ACK/ETX response deframer.
package stxd_pkg;

  localparam int MAX_PAYLOAD_DEFAULT = 256;

  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_NAK = 8'h15;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_OOD      = 2'd2;
  localparam logic [1:0] ST_RESP_ERR = 2'd3;

  typedef enum logic [2:0] {
    PH_WAIT_STX = 3'd0,
    PH_WAIT_ACK = 3'd1,
    PH_PAYLOAD  = 3'd2,
    PH_DONE     = 3'd3,
    PH_ABORT    = 3'd4
  } phase_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [1:0] frame_status;
    logic       nak_seen;
    logic       payload_overflow;
    logic [8:0] payload_length;
  } result_t;

  // Result of one accepted item, handed from the frame tracker to the output stage.
  typedef struct packed {
    logic    valid;
    result_t data;
  } frame_out_t;

endpackage

/* src/stxd_frame.sv */
// Frame tracker: phase state, error and payload counters, and per-item result.
module stxd_frame #(
  parameter int MAX_PAYLOAD = stxd_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  stxd_pkg::item_t     item,
  output stxd_pkg::frame_out_t frame_out
);

  `include "stx_ack_etx_response_deframer_assert.svh"

  localparam logic [8:0] PayloadLimit = (MAX_PAYLOAD > 511) ? 9'd511 : 9'(MAX_PAYLOAD);

  stxd_pkg::phase_t phase, phase_next;
  logic [1:0] framing_errors, framing_errors_next;
  logic       nak_flag, nak_flag_next;
  logic       response_error_flag, response_error_flag_next;
  logic [8:0] payload_count, payload_count_next;
  logic       overflow_flag, overflow_flag_next;

  logic [1:0] slot_errs_base;
  logic       slot_bad;
  logic [1:0] slot_errs;
  logic       slot_abort;
  logic       room;

  // The acknowledge slot is judged either on its own byte or, when the start
  // byte was missing, on the first byte after one framing error is counted.
  always_comb begin
    slot_errs_base = (phase == stxd_pkg::PH_WAIT_STX) ? 2'(framing_errors + 2'd1)
                                                      : framing_errors;
    slot_bad   = (item.rx_byte != stxd_pkg::BYTE_ACK) && (item.rx_byte != stxd_pkg::BYTE_NAK);
    slot_errs  = (slot_bad && slot_errs_base != 2'd3) ? 2'(slot_errs_base + 2'd1)
                                                      : slot_errs_base;
    slot_abort = slot_errs > 2'd1;
    room       = payload_count < PayloadLimit;
  end

  always_comb begin
    phase_next               = phase;
    framing_errors_next      = framing_errors;
    nak_flag_next            = nak_flag;
    response_error_flag_next = response_error_flag;
    payload_count_next       = payload_count;
    overflow_flag_next       = overflow_flag;
    if (accept) begin
      if (item.mode) begin
        phase_next               = stxd_pkg::PH_WAIT_STX;
        framing_errors_next      = 2'd0;
        nak_flag_next            = 1'b0;
        response_error_flag_next = 1'b0;
        payload_count_next       = 9'd0;
        overflow_flag_next       = 1'b0;
      end else begin
        case (phase)
          stxd_pkg::PH_WAIT_STX, stxd_pkg::PH_WAIT_ACK: begin
            if (phase == stxd_pkg::PH_WAIT_STX && item.rx_byte == stxd_pkg::BYTE_STX) begin
              phase_next = stxd_pkg::PH_WAIT_ACK;
            end else begin
              framing_errors_next = slot_errs;
              if (slot_abort) begin
                phase_next               = stxd_pkg::PH_ABORT;
                response_error_flag_next = 1'b1;
              end else begin
                phase_next = stxd_pkg::PH_PAYLOAD;
              end
              if (item.rx_byte == stxd_pkg::BYTE_NAK) begin
                nak_flag_next = 1'b1;
              end
            end
          end
          stxd_pkg::PH_PAYLOAD: begin
            if (item.rx_byte == stxd_pkg::BYTE_ETX) begin
              phase_next = stxd_pkg::PH_DONE;
            end else if (!room) begin
              overflow_flag_next = 1'b1;
            end else begin
              payload_count_next = 9'(payload_count + 9'd1);
            end
          end
          stxd_pkg::PH_DONE: begin
            response_error_flag_next = 1'b1;
            phase_next               = stxd_pkg::PH_ABORT;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    frame_out      = '0;
    if (item.mode) begin
      frame_out.data.is_status        = 1'b1;
      frame_out.data.payload_overflow = overflow_flag;
      frame_out.data.payload_length   = payload_count;
      case (phase)
        stxd_pkg::PH_WAIT_STX: frame_out.data.frame_status = stxd_pkg::ST_TIMEOUT;
        stxd_pkg::PH_WAIT_ACK, stxd_pkg::PH_PAYLOAD: begin
          frame_out.data.frame_status = stxd_pkg::ST_OOD;
        end
        stxd_pkg::PH_DONE: begin
          frame_out.data.frame_status = response_error_flag ? stxd_pkg::ST_RESP_ERR
                                                            : stxd_pkg::ST_OK;
          frame_out.data.nak_seen     = nak_flag;
        end
        default: begin
          frame_out.data.frame_status = stxd_pkg::ST_RESP_ERR;
          frame_out.data.nak_seen     = nak_flag;
        end
      endcase
      frame_out.valid = accept;
    end else begin
      frame_out.data.payload_byte  = item.rx_byte;
      frame_out.data.payload_index = payload_count[7:0];
      frame_out.valid = accept && phase == stxd_pkg::PH_PAYLOAD
                        && item.rx_byte != stxd_pkg::BYTE_ETX && room;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= stxd_pkg::PH_WAIT_STX;
      framing_errors      <= 2'd0;
      nak_flag            <= 1'b0;
      response_error_flag <= 1'b0;
      payload_count       <= 9'd0;
      overflow_flag       <= 1'b0;
    end else begin
      phase               <= phase_next;
      framing_errors      <= framing_errors_next;
      nak_flag            <= nak_flag_next;
      response_error_flag <= response_error_flag_next;
      payload_count       <= payload_count_next;
      overflow_flag       <= overflow_flag_next;
    end
  end

  `STXD_ASSERT_NOW(a_abort_flags, phase == stxd_pkg::PH_ABORT, response_error_flag,
                   "aborted frame without response error flag")
  `STXD_ASSERT_NOW(a_count_limit, 1'b1, payload_count <= PayloadLimit,
                   "payload count beyond limit")
  `STXD_ASSERT_NEXT(a_status_rearms, accept && item.mode,
                    phase == stxd_pkg::PH_WAIT_STX && payload_count == 9'd0,
                    "end of data did not rearm")

endmodule

/* src/stx_ack_etx_response_deframer.sv */
// Top level of the STX/ACK/ETX response deframer with its output register and skid stage.
//
//   Channel   Direction  Handshake                 Payload
//   item      in         item_valid / item_stall   stxd_pkg::item_t (mode, rx_byte)
//   result    out        result_valid / result_stall  stxd_pkg::result_t
//
// One transaction is accepted per cycle while item_stall is low. The frame state is updated at
// the accepting edge, and the item's result is registered at that edge in the output register or skid.
// Reset (rst, synchronous) rearms the frame tracker and empties the output register and skid.
// A stalled result is held; one more result lands in the skid stage, and item_stall rises only
// while the skid stage is full, so the input side never waits on a combinational stall path.
module stx_ack_etx_response_deframer #(
  parameter int MAX_PAYLOAD = stxd_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  stxd_pkg::item_t    item,
  output logic               result_valid,
  input  logic               result_stall,
  output stxd_pkg::result_t  result
);

  `include "stx_ack_etx_response_deframer_assert.svh"

  stxd_pkg::frame_out_t frame_out;
  logic                 accept;
  logic                 take;
  logic                 skid_valid;
  stxd_pkg::result_t    skid;

  // Input is held off only while the skid stage already holds a waiting result.
  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign take       = result_valid && !result_stall;

  stxd_frame #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_frame (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .frame_out(frame_out)
  );

  // The output register refills from the skid stage first, so results keep their order.
  // A new result only arrives while the skid stage is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || take) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= frame_out.valid;
      end
    end else if (frame_out.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || take) begin
      result <= skid_valid ? skid : frame_out.data;
    end
    if (result_valid && !take && frame_out.valid) begin
      skid <= frame_out.data;
    end
  end

  `STXD_ASSERT_NOW(a_skid_behind_out, skid_valid, result_valid,
                   "skid stage full while output register empty")
  `STXD_ASSERT_NEXT(a_skid_catches, result_valid && result_stall && frame_out.valid,
                    skid_valid, "held result overrun without skid capture")
  `STXD_ASSERT_NEXT(a_skid_drains, take && skid_valid, result_valid && !skid_valid,
                    "skid stage did not move into output register")

endmodule
